### design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned SlotsDef     = 256;
  localparam int unsigned KeyBytesDef  = 8;
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned ValW   = 32;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned StatW  = 2;
  localparam int unsigned SlotW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned CapW   = 9;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 3'd0,
    MODE_ERASE  = 3'd1,
    MODE_SEARCH = 3'd2,
    MODE_FIRST  = 3'd3,
    MODE_NEXT   = 3'd4
  } mode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_MOD, S_RD, S_CHK, S_WR, S_SCAN_RD, S_SCAN_CHK, S_OUT
  } state_e;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [KeyW-1:0]   key;
    logic [ValW-1:0]   value;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [SlotW-1:0]  slot_index;
    logic [KeyW-1:0]   found_key;
    logic [ValW-1:0]   found_value;
    logic [CountW-1:0] entry_count;
  } rsp_t;

endpackage

### design/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface lpht_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressing hash table with linear probing over slot memories.
// ----------------------------------------------------------------------------
// An item enters on req (mode, key, value) and one result item leaves on rsp
// (status, slot_index, found_key, found_value, entry_count). cfg_we_i writes
// the capacity; the user must write it only while the block is idle, which
// the block itself does not enforce. Insert, erase and search hash the key
// one byte per cycle and reduce it modulo the capacity one bit per cycle,
// then probe each slot visited through the memory read port in a read state
// and a check state. First and next scan slots the same way. One item is
// worked on at a time; a result waits in the output register while the
// receiver stalls, and the next item is taken once that result has left.
// After reset a clearing pass marks every slot empty; no item is accepted
// until it ends.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
  parameter int unsigned SLOTS      = lpht_pkg::SlotsDef,
  parameter int unsigned KEY_BYTES  = lpht_pkg::KeyBytesDef,
  parameter int unsigned VALUE_BITS = lpht_pkg::ValueBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lpht_pkg::CapW-1:0] cfg_wdata_i,
  lpht_if.sink                      req,
  lpht_if.source                    rsp
);
  import lpht_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS+1);

  logic [1:0]       mark_mem [SLOTS];
  logic [KeyW-1:0]  key_mem  [SLOTS];
  logic [ValW-1:0]  val_mem  [SLOTS];

  state_e st_q, st_d;
  logic [CapW-1:0] cap_q;
  logic [CW-1:0]   cap_eff;
  logic [SW:0]     clr_q, clr_d;
  req_t            rq_q, rq_d;
  rsp_t            out_q, out_d;
  logic            ov_q, ov_d;
  logic [SW-1:0]   p_q, p_d, start_q, start_d;
  logic [CW-1:0]   sp_q, sp_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]   cur_q, cur_d;
  logic            curset_q, curset_d;
  logic [SW-1:0]   rd_addr;
  logic            we;
  logic [SW-1:0]   wa;
  logic [1:0]      wm;
  logic            wkv;
  logic [1:0]      rd_mark;
  logic [KeyW-1:0] rd_key;
  logic [ValW-1:0] rd_val;
  logic            hstart, hdone;
  logic [KeyW-1:0] nkey;
  logic [SW-1:0]   home;
  logic [SW-1:0]   pnext;
  logic [ValW-1:0] vmask;

  always_comb begin
    if (cap_q == '0) cap_eff = CW'(1);
    else if (32'(cap_q) > SLOTS) cap_eff = CW'(SLOTS);
    else cap_eff = CW'(cap_q);
    pnext = (32'(p_q) + 1 >= 32'(cap_eff)) ? '0 : p_q + SW'(1);
    for (int i = 0; i < ValW; i++) vmask[i] = (i < VALUE_BITS);
  end

  lpht_hash #(.KEY_BYTES(KEY_BYTES), .SLOTS(SLOTS)) u_hash (
    .clk_i, .rst_ni, .start_i(hstart), .key_i(rq_q.key), .cap_i(cap_eff),
    .done_o(hdone), .norm_key_o(nkey), .home_o(home)
  );

  always_ff @(posedge clk_i) begin
    rd_mark <= mark_mem[rd_addr];
    rd_key  <= key_mem[rd_addr];
    rd_val  <= val_mem[rd_addr];
    if (we) begin
      mark_mem[wa] <= wm;
      if (wkv) begin
        key_mem[wa] <= nkey;
        val_mem[wa] <= rq_q.value & vmask;
      end
    end
  end

  assign req.ready = (st_q == S_IDLE) && !ov_q && clr_q[SW];
  assign rsp.valid = ov_q;
  assign rsp.data  = out_q;

  always_comb begin
    st_d = st_q; clr_d = clr_q; rq_d = rq_q; out_d = out_q; ov_d = ov_q;
    p_d = p_q; start_d = start_q; sp_d = sp_q; cnt_d = cnt_q;
    cur_d = cur_q; curset_d = curset_q;
    rd_addr = p_q; we = 1'b0; wa = p_q; wm = MARK_EMPTY; wkv = 1'b0; hstart = 1'b0;
    if (ov_q && rsp.ready) ov_d = 1'b0;
    if (!clr_q[SW]) begin
      we = 1'b1; wa = clr_q[SW-1:0]; wm = MARK_EMPTY;
      clr_d = clr_q + (SW+1)'(1);
    end
    case (st_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          rq_d = req.data;
          out_d = '0;
          out_d.status = ST_NOTFOUND;
          case (req.data.mode)
            MODE_INSERT, MODE_ERASE, MODE_SEARCH: st_d = S_HASH;
            MODE_FIRST: begin
              sp_d = '0; st_d = S_SCAN_RD;
            end
            MODE_NEXT: begin
              sp_d = curset_q ? CW'(cur_q) + CW'(1) : '0; st_d = S_SCAN_RD;
            end
            default: st_d = S_OUT;
          endcase
        end
      end
      S_HASH: begin
        hstart = 1'b1; st_d = S_MOD;
      end
      S_MOD: begin
        if (hdone) begin
          p_d = home; start_d = home; st_d = S_RD;
        end
      end
      S_RD: begin
        rd_addr = p_q; st_d = S_CHK;
      end
      S_CHK: begin
        if (rd_mark == MARK_EMPTY) begin
          if (rq_q.mode == MODE_INSERT) st_d = S_WR;
          else st_d = S_OUT;
        end else if (rd_mark == MARK_LIVE && rd_key == nkey) begin
          out_d.slot_index  = SlotW'(p_q);
          out_d.found_key   = rd_key;
          out_d.found_value = rd_val;
          st_d = S_OUT;
          case (rq_q.mode)
            MODE_INSERT: out_d.status = ST_DUP;
            MODE_ERASE: begin
              out_d.status = ST_OK;
              we = 1'b1; wa = p_q; wm = MARK_TOMB;
              cnt_d = cnt_q - CountW'(1);
            end
            default: begin
              out_d.status = ST_OK; cur_d = p_q; curset_d = 1'b1;
            end
          endcase
        end else if (pnext == start_q) begin
          if (rq_q.mode == MODE_INSERT) out_d.status = ST_FULL;
          st_d = S_OUT;
        end else begin
          p_d = pnext; st_d = S_RD;
        end
      end
      S_WR: begin
        we = 1'b1; wa = p_q; wm = MARK_LIVE; wkv = 1'b1;
        cnt_d = cnt_q + CountW'(1);
        cur_d = p_q; curset_d = 1'b1;
        out_d.status = ST_OK;
        out_d.slot_index = SlotW'(p_q);
        out_d.found_key = nkey;
        out_d.found_value = rq_q.value & vmask;
        st_d = S_OUT;
      end
      S_SCAN_RD: begin
        rd_addr = sp_q[SW-1:0];
        if (sp_q >= cap_eff) st_d = S_OUT;
        else st_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd_mark == MARK_LIVE) begin
          out_d.status = ST_OK;
          out_d.slot_index = SlotW'(sp_q);
          out_d.found_key = rd_key;
          out_d.found_value = rd_val;
          cur_d = sp_q[SW-1:0]; curset_d = 1'b1;
          st_d = S_OUT;
        end else begin
          sp_d = sp_q + CW'(1); st_d = S_SCAN_RD;
        end
      end
      S_OUT: begin
        out_d.entry_count = cnt_q;
        ov_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; clr_q <= '0; ov_q <= 1'b0; cnt_q <= '0;
      curset_q <= 1'b0; cur_q <= '0; cap_q <= CapW'(256);
    end else begin
      st_q <= st_d; clr_q <= clr_d; ov_q <= ov_d; cnt_q <= cnt_d;
      curset_q <= curset_d; cur_q <= cur_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; out_q <= out_d; p_q <= p_d; start_q <= start_d; sp_q <= sp_d;
  end
endmodule

### design/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash
// Key normalization and case folding hash, one byte per cycle, followed by
// a restoring reduction modulo the capacity, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpht_hash #(
  parameter int unsigned KEY_BYTES = 8,
  parameter int unsigned SLOTS     = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lpht_pkg::KeyW-1:0]   key_i,
  input  logic [$clog2(SLOTS+1)-1:0]  cap_i,
  output logic                        done_o,
  output logic [lpht_pkg::KeyW-1:0]   norm_key_o,
  output logic [$clog2(SLOTS)-1:0]    home_o
);
  import lpht_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS+1);
  localparam int unsigned SW = $clog2(SLOTS);

  logic        hbusy_q, hbusy_d, mbusy_q, mbusy_d, done_q, done_d;
  logic [3:0]  bidx_q, bidx_d;
  logic [6:0]  mbit_q, mbit_d;
  logic        stop_q, stop_d;
  logic [63:0] h_q, h_d;
  logic [KeyW-1:0] k_q, k_d, nk_q, nk_d;
  logic [CW:0] r_q, r_d;
  logic [7:0]  b, bl;
  logic [CW+1:0] trial;

  always_comb begin
    b  = k_q[8*bidx_q[2:0] +: 8];
    bl = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    trial = {r_q, h_q[mbit_q[5:0]]} - {2'b0, cap_i};
  end

  always_comb begin
    hbusy_d = hbusy_q; mbusy_d = mbusy_q; done_d = 1'b0;
    bidx_d = bidx_q; mbit_d = mbit_q; stop_d = stop_q;
    h_d = h_q; k_d = k_q; nk_d = nk_q; r_d = r_q;
    if (start_i) begin
      hbusy_d = 1'b1; bidx_d = '0; stop_d = 1'b0; h_d = '0; k_d = key_i; nk_d = '0;
    end else if (hbusy_q) begin
      if (!stop_q && b != 8'd0 && bidx_q < 4'(KEY_BYTES)) begin
        h_d = (h_q << 5) + h_q + {56'd0, bl};
        nk_d[8*bidx_q[2:0] +: 8] = b;
      end else begin
        stop_d = 1'b1;
      end
      if (bidx_q == 4'd7) begin
        hbusy_d = 1'b0; mbusy_d = 1'b1; mbit_d = 7'd63; r_d = '0;
      end
      bidx_d = bidx_q + 4'd1;
    end else if (mbusy_q) begin
      if (!trial[CW+1]) r_d = trial[CW:0];
      else r_d = {r_q[CW-1:0], h_q[mbit_q[5:0]]};
      if (mbit_q == 7'd0) begin
        mbusy_d = 1'b0; done_d = 1'b1;
      end
      mbit_d = mbit_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hbusy_q <= 1'b0; mbusy_q <= 1'b0; done_q <= 1'b0;
      bidx_q <= '0; mbit_q <= '0; stop_q <= 1'b0;
    end else begin
      hbusy_q <= hbusy_d; mbusy_q <= mbusy_d; done_q <= done_d;
      bidx_q <= bidx_d; mbit_q <= mbit_d; stop_q <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d; k_q <= k_d; nk_q <= nk_d; r_q <= r_d;
  end

  assign done_o     = done_q;
  assign norm_key_o = nk_q;
  assign home_o     = r_q[SW-1:0];
endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hash table core testbench
// Drives insert, erase, search, first and next items through the request
// channel, predicts each result with a behavioral table and compares it
// with the response channel field by field under several capacities.
// ----------------------------------------------------------------------------
module testbench;
  import lpht_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CapW-1:0] cfg_wdata;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  int unsigned err_cnt;
  int unsigned left_cnt;

  lpht_if #(.T(req_t)) req_ch ();
  lpht_if #(.T(rsp_t)) rsp_ch ();

  mark_e           tbl_mark [256];
  logic [KeyW-1:0] tbl_key  [256];
  logic [ValW-1:0] tbl_val  [256];
  int unsigned     tbl_live;
  int              tbl_cursor;
  int unsigned     tbl_cap;
  rsp_t            expected_rsp_q [$];
  logic [KeyW-1:0] known_keys [$];

  linear_probe_hash_table_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req         (req_ch.sink),
    .rsp         (rsp_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [KeyW-1:0] trim_key(logic [KeyW-1:0] k);
    logic [KeyW-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (k[8*i +: 8] == 8'h00) break;
      r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  function automatic int unsigned home_slot(logic [KeyW-1:0] k, int unsigned cap);
    logic [63:0] h;
    logic [7:0] b;
    h = '0;
    for (int i = 0; i < 8; i++) begin
      b = k[8*i +: 8];
      if (b == 8'h00) break;
      if (b >= "A" && b <= "Z") b = b + 8'd32;
      h = h * 64'd33 + 64'(b);
    end
    return int'(h % 64'(cap));
  endfunction

  function automatic int lookup_slot(logic [KeyW-1:0] k, int unsigned cap);
    int unsigned start;
    int unsigned p;
    start = home_slot(k, cap);
    p = start;
    while (tbl_mark[p] != MARK_EMPTY) begin
      if (tbl_mark[p] == MARK_LIVE && tbl_key[p] == k) return p;
      p = (p + 1) % cap;
      if (p == start) break;
    end
    return -1;
  endfunction

  function automatic rsp_t apply_op(req_t r);
    rsp_t o;
    logic [KeyW-1:0] k;
    int unsigned cap;
    int unsigned start;
    int unsigned p;
    int s;
    status_e st;
    k = trim_key(r.key);
    cap = (tbl_cap == 0) ? 1 : (tbl_cap > 256) ? 256 : tbl_cap;
    st = ST_NOTFOUND;
    s = -1;
    case (r.mode)
      MODE_INSERT: begin
        start = home_slot(k, cap);
        p = start;
        st = ST_OK;
        while (tbl_mark[p] != MARK_EMPTY) begin
          if (tbl_mark[p] == MARK_LIVE && tbl_key[p] == k) begin
            st = ST_DUP;
            break;
          end
          p = (p + 1) % cap;
          if (p == start) begin
            st = ST_FULL;
            break;
          end
        end
        if (st == ST_OK) begin
          tbl_mark[p] = MARK_LIVE;
          tbl_key[p] = k;
          tbl_val[p] = r.value;
          tbl_live++;
          tbl_cursor = p;
        end
        if (st != ST_FULL) s = p;
      end
      MODE_ERASE: begin
        s = lookup_slot(k, cap);
        if (s >= 0) begin
          tbl_mark[s] = MARK_TOMB;
          tbl_live--;
          st = ST_OK;
        end
      end
      MODE_SEARCH: begin
        s = lookup_slot(k, cap);
        if (s >= 0) st = ST_OK;
      end
      MODE_FIRST, MODE_NEXT: begin
        start = (r.mode == MODE_NEXT && tbl_cursor >= 0) ? tbl_cursor + 1 : 0;
        for (p = start; p < cap; p++) begin
          if (tbl_mark[p] == MARK_LIVE) begin
            s = p;
            st = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    if (s >= 0 && st == ST_OK && r.mode >= MODE_SEARCH) tbl_cursor = s;
    o.status = st;
    o.slot_index = (s >= 0) ? s[7:0] : '0;
    o.found_key = (s >= 0) ? tbl_key[s] : '0;
    o.found_value = (s >= 0) ? tbl_val[s] : '0;
    o.entry_count = tbl_live[CountW-1:0];
    return o;
  endfunction

  task automatic send_op(mode_e m, logic [KeyW-1:0] k, logic [ValW-1:0] v);
    req_t r;
    r.mode = m;
    r.key = k;
    r.value = v;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_rsp_q.push_back(apply_op(r));
    if (trim_key(k) != 0) known_keys.push_back(k);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CapW-1:0] c);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    tbl_cap = c;
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    logic [KeyW-1:0] k;
    int unsigned n;
    k = {$urandom, $urandom};
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(8, 1);
        for (int i = 0; i < 8; i++)
          k[8*i +: 8] = (i < n) ? 8'($urandom_range(90, 65) + 32 * $urandom_range(1))
                                : 8'($urandom_range(1) ? 0 : $urandom);
      end
      1: if (known_keys.size() != 0)
        k = known_keys[$urandom_range(known_keys.size() - 1)];
      2: k[8*$urandom_range(7) +: 8] = 8'h00;
      default: ;
    endcase
    return k;
  endfunction

  task automatic run_random(int unsigned count);
    int unsigned sel;
    mode_e m;
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      m = (sel < 45) ? MODE_INSERT : (sel < 60) ? MODE_ERASE : (sel < 80) ? MODE_SEARCH :
          (sel < 85) ? MODE_FIRST : MODE_NEXT;
      send_op(m, rand_key(), $urandom);
    end
  endtask

  task automatic test_directed();
    send_op(MODE_NEXT, 64'h0, 32'h0);
    send_op(MODE_FIRST, 64'h0, 32'h0);
    send_op(MODE_SEARCH, 64'h61, 32'h0);
    send_op(MODE_INSERT, 64'h0, 32'hFFFF_FFFF);
    send_op(MODE_INSERT, 64'h0, 32'h1);
    send_op(MODE_INSERT, 64'h4142_4344_4546_4748, 32'h1234_5678);
    send_op(MODE_INSERT, 64'h6162_6364_6566_6768, 32'h0);
    send_op(MODE_SEARCH, 64'h4142_4344_4546_4748, 32'h0);
    send_op(MODE_INSERT, 64'hFFFF_FF00_0000_0041, 32'h5);
    send_op(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_A5A5);
    send_op(MODE_SEARCH, 64'h41, 32'h0);
    send_op(MODE_ERASE, 64'h41, 32'h0);
    send_op(MODE_ERASE, 64'h41, 32'h0);
    send_op(MODE_FIRST, 64'h0, 32'h0);
    repeat (6) send_op(MODE_NEXT, 64'h0, 32'h0);
    send_op(MODE_INSERT, 64'h41, 32'h7);
  endtask

  task automatic test_tiny_capacity();
    set_capacity(9'd1);
    send_op(MODE_INSERT, 64'h7A, 32'h1);
    send_op(MODE_INSERT, 64'h79, 32'h2);
    send_op(MODE_INSERT, 64'h7A, 32'h3);
    send_op(MODE_ERASE, 64'h7A, 32'h0);
    send_op(MODE_INSERT, 64'h78, 32'h4);
    set_capacity(9'd0);
    send_op(MODE_SEARCH, 64'h7A, 32'h0);
    send_op(MODE_INSERT, 64'h77, 32'h5);
    set_capacity(9'd3);
    run_random(40);
    set_capacity(9'd511);
    run_random(30);
  endtask

  task automatic test_idling();
    set_capacity(9'd256);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(300);
    set_capacity(9'd17);
    send_idle_pct = 75;
    run_random(250);
    set_capacity(9'd64);
    send_idle_pct = 0;
    recv_stall_pct = 75;
    run_random(300);
    set_capacity(9'd200);
    send_idle_pct = 36;
    recv_stall_pct = 36;
    run_random(300);
    set_capacity(9'd256);
    run_random(300);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 3000;
    run_random(20);
    wait_drained();
    run_random(60);
  endtask

  always @(posedge clk) begin
    rsp_t got;
    rsp_t exp_r;
    if (rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected result item");
        err_cnt++;
      end else begin
        exp_r = expected_rsp_q.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got.status);
          err_cnt++;
        end
        if (got.slot_index !== exp_r.slot_index) begin
          $error("slot_index: expected %0d, got %0d", exp_r.slot_index, got.slot_index);
          err_cnt++;
        end
        if (got.found_key !== exp_r.found_key) begin
          $error("found_key: expected %h, got %h", exp_r.found_key, got.found_key);
          err_cnt++;
        end
        if (got.found_value !== exp_r.found_value) begin
          $error("found_value: expected %h, got %h", exp_r.found_value, got.found_value);
          err_cnt++;
        end
        if (got.entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, got.entry_count);
          err_cnt++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    err_cnt = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    tbl_live = 0;
    tbl_cursor = -1;
    tbl_cap = 256;
    foreach (tbl_mark[i]) tbl_mark[i] = MARK_EMPTY;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_tiny_capacity();
    test_idling();
    test_backpressure();
    req_ch.valid <= 1'b0;
    left_cnt = 0;
    while (expected_rsp_q.size() != 0 && left_cnt < 200000) begin
      @(negedge clk);
      left_cnt++;
    end
    repeat (100) @(negedge clk);
    if (err_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
design/lpht_pkg.sv
design/lpht_if.sv
design/lpht_hash.sv
design/linear_probe_hash_table_core.sv
tb/testbench.sv
